FILE: rtl/core/ahpc_pkg.sv
package ahpc_pkg;

  // default build values for the top level parameters
  localparam int DEF_GAIN_DENOMINATOR = 16;
  localparam int DEF_MIN_DUTY         = 100;
  localparam int DEF_MAX_DUTY         = 1000;
  localparam int DEF_HOMING_DUTY      = 1000;
  localparam int DEF_COUNT_SIGN       = 1;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_POS_MIN       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POS_MAX       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOME_TIMEOUT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HOME_MIN_RUN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STALL_THR     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STALL_STABLE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MOVE_DEADBAND = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_NUM      = 3'd7;

  // register reset values
  localparam logic signed [31:0] RST_POS_MIN       = 32'sd0;
  localparam logic signed [31:0] RST_POS_MAX       = 32'sd65535;
  localparam logic [31:0]        RST_HOME_TIMEOUT  = 32'd10000;
  localparam logic [31:0]        RST_HOME_MIN_RUN  = 32'd300;
  localparam logic [14:0]        RST_STALL_THR     = 15'd10;
  localparam logic [31:0]        RST_STALL_STABLE  = 32'd200;
  localparam logic [30:0]        RST_MOVE_DEADBAND = 31'd5;
  localparam logic [15:0]        RST_GAIN_NUM      = 16'd16;

  // action codes
  localparam logic [2:0] ACT_TICK = 3'd0;
  localparam logic [2:0] ACT_INIT = 3'd1;
  localparam logic [2:0] ACT_HOME = 3'd2;
  localparam logic [2:0] ACT_MOVE = 3'd3;
  localparam logic [2:0] ACT_DUTY = 3'd4;

  // controller modes
  localparam logic [2:0] MODE_UNINIT = 3'd0;
  localparam logic [2:0] MODE_IDLE   = 3'd1;
  localparam logic [2:0] MODE_HOMING = 3'd2;
  localparam logic [2:0] MODE_HOMED  = 3'd3;
  localparam logic [2:0] MODE_MOVING = 3'd4;
  localparam logic [2:0] MODE_FAULT  = 3'd5;

  // motor commands
  localparam logic [1:0] CMD_NONE     = 2'd0;
  localparam logic [1:0] CMD_SET_DUTY = 2'd1;
  localparam logic [1:0] CMD_STOP     = 2'd2;

  // no target stored
  localparam logic signed [31:0] TARGET_NONE = -32'sd1;

  typedef struct packed {
    logic [2:0]         action;
    logic [31:0]        now_ms;
    logic signed [15:0] measured_speed;
    logic signed [31:0] raw_count;
    logic signed [31:0] target_position;
    logic signed [15:0] requested_duty;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         motor_command;
    logic signed [15:0] duty_out;
    logic               counter_reset;
    logic [2:0]         controller_state;
    logic signed [31:0] position_out;
    logic signed [31:0] target_out;
    logic               command_accepted;
  } out_word_t;

endpackage

FILE: rtl/core/ahpc_in_if.sv
interface ahpc_in_if
  import ahpc_pkg::*;
();
  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/ahpc_out_if.sv
interface ahpc_out_if
  import ahpc_pkg::*;
();
  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/actuator_homing_and_position_controller_core.sv
// Controller for one actuator: homing by stall detection, proportional
// position control and direct duty requests.
// in_ch carries one word per action (tick, init, start homing, move, direct
// duty); out_ch returns exactly one result word per input word, in order.
// The user must write registers through cfg_we_i / cfg_idx_i / cfg_data_i only
// while idle; the block itself does not enforce this. The controller state
// updates at the input handshake, then the proportional duty goes through
// a gain multiply stage, a reciprocal multiply stage for the gain denominator
// and a final min/max clamp stage into the output register.
// Throughput is one word per cycle unless out_ch stalls; every stage is a
// register with its own valid bit, so bubbles are squeezed out and in_ch.ready
// stays high while the pipeline has a free slot even if out_ch is stalled.
// When out_ch.ready is low the result word holds and the stages behind it fill
// up; in_ch.ready drops once all four stages are occupied.
// Reset clears the pipeline, sets the mode to uninit, the target to none, the
// timers and position to zero and loads the register defaults.
module actuator_homing_and_position_controller_core
  import ahpc_pkg::*;
#(
  parameter int GAIN_DENOMINATOR = DEF_GAIN_DENOMINATOR,
  parameter int MIN_DUTY         = DEF_MIN_DUTY,
  parameter int MAX_DUTY         = DEF_MAX_DUTY,
  parameter int HOMING_DUTY      = DEF_HOMING_DUTY,
  parameter int COUNT_SIGN       = DEF_COUNT_SIGN
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  ahpc_in_if.sink               in_ch,
  ahpc_out_if.source            out_ch
);

  // reciprocal division by the gain denominator, exact below the clamp limit
  localparam longint unsigned ScaleLim = longint'(MAX_DUTY) * longint'(GAIN_DENOMINATOR);
  localparam int NumW   = $clog2(ScaleLim + 64'd1);
  localparam int ShiftL = $clog2(GAIN_DENOMINATOR);
  localparam int RecipS = NumW + ShiftL;
  localparam longint unsigned Recip =
    ((64'd1 << RecipS) + longint'(GAIN_DENOMINATOR) - 64'd1) / longint'(GAIN_DENOMINATOR);
  localparam int PrdW   = 2 * NumW + 1;

  // configuration registers
  logic signed [31:0] pos_min_q, pos_max_q;
  logic [31:0]        home_timeout_q, home_min_run_q, stall_stable_q;
  logic [14:0]        stall_thr_q;
  logic [30:0]        deadband_q;
  logic [15:0]        gain_num_q;

  // controller state
  logic [2:0]         mode_q, mode_d;
  logic [31:0]        prev_tick_q, prev_tick_d;
  logic [31:0]        home_el_q, home_el_d;
  logic [31:0]        stall_el_q, stall_el_d;
  logic signed [31:0] pos_q, pos_d;
  logic signed [31:0] tgt_q, tgt_d;

  // pipeline
  logic               v1_q, v2_q, v3_q, vo_q;
  logic               rdy1, rdy2, rdy3, rdy_o;
  logic               in_acc;
  out_word_t          res1_d, res1_q, res2_q, res3_q, out_d, out_q;
  logic               prop1_d, prop1_q, prop2_q, prop3_q;
  logic signed [32:0] negerr1_d, negerr1_q;
  logic signed [49:0] prod2_d, prod2_q;
  logic [49:0]        mag3;
  logic               neg3_q, sat3_q;
  logic [PrdW-1:0]    recip3_d, recip3_q;
  logic [PrdW-1:0]    quot, raised, limited, fin_mag;
  logic signed [15:0] prop_duty;

  // input decode
  logic signed [32:0] raw_ext, signed_raw;
  logic signed [31:0] sensed, move_tgt;
  logic [31:0]        dt;
  logic [32:0]        home_sum, stall_sum;
  logic [31:0]        home_sat, stall_sat;
  logic signed [16:0] spd_ext, thr_ext;
  logic               is_still;
  logic signed [32:0] err;
  logic signed [33:0] err_ext, db_ext;
  logic               in_band;
  logic signed [16:0] gain_s;

  function automatic logic signed [31:0] clamp_pos(input logic signed [32:0] v,
                                                   input logic signed [31:0] lo,
                                                   input logic signed [31:0] hi);
    logic signed [32:0] lo_ext;
    logic signed [32:0] hi_ext;
    logic signed [31:0] r;
    lo_ext = {lo[31], lo};
    hi_ext = {hi[31], hi};
    if (v < lo_ext) begin
      r = lo;
    end else if (v > hi_ext) begin
      r = hi;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // handshake chain
  assign rdy_o       = !vo_q || out_ch.ready;
  assign rdy3        = !v3_q || rdy_o;
  assign rdy2        = !v2_q || rdy3;
  assign rdy1        = !v1_q || rdy2;
  assign in_ch.ready = rdy1;
  assign in_acc      = in_ch.valid && rdy1;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_min_q      <= RST_POS_MIN;
      pos_max_q      <= RST_POS_MAX;
      home_timeout_q <= RST_HOME_TIMEOUT;
      home_min_run_q <= RST_HOME_MIN_RUN;
      stall_thr_q    <= RST_STALL_THR;
      stall_stable_q <= RST_STALL_STABLE;
      deadband_q     <= RST_MOVE_DEADBAND;
      gain_num_q     <= RST_GAIN_NUM;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_POS_MIN:       pos_min_q      <= cfg_data_i;
        REG_POS_MAX:       pos_max_q      <= cfg_data_i;
        REG_HOME_TIMEOUT:  home_timeout_q <= cfg_data_i;
        REG_HOME_MIN_RUN:  home_min_run_q <= cfg_data_i;
        REG_STALL_THR:     stall_thr_q    <= cfg_data_i[14:0];
        REG_STALL_STABLE:  stall_stable_q <= cfg_data_i;
        REG_MOVE_DEADBAND: deadband_q     <= cfg_data_i[30:0];
        REG_GAIN_NUM:      gain_num_q     <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // sensed position from the raw hall count
  assign raw_ext = {in_ch.data.raw_count[31], in_ch.data.raw_count};
  assign signed_raw = (COUNT_SIGN > 0) ? raw_ext :
                      (COUNT_SIGN < 0) ? -raw_ext : '0;
  assign sensed   = clamp_pos(signed_raw, pos_min_q, pos_max_q);
  assign move_tgt = clamp_pos({in_ch.data.target_position[31], in_ch.data.target_position},
                              pos_min_q, pos_max_q);

  // elapsed time with saturating run timers
  assign dt        = (prev_tick_q != '0) ? (in_ch.data.now_ms - prev_tick_q) : '0;
  assign home_sum  = {1'b0, home_el_q} + {1'b0, dt};
  assign stall_sum = {1'b0, stall_el_q} + {1'b0, dt};
  assign home_sat  = home_sum[32] ? '1 : home_sum[31:0];
  assign stall_sat = stall_sum[32] ? '1 : stall_sum[31:0];

  // stall window on the speed magnitude
  assign spd_ext  = {in_ch.data.measured_speed[15], in_ch.data.measured_speed};
  assign thr_ext  = {2'b00, stall_thr_q};
  assign is_still = (spd_ext <= thr_ext) && (spd_ext >= -thr_ext);

  // position error and deadband
  assign err     = {tgt_q[31], tgt_q} - {sensed[31], sensed};
  assign err_ext = {err[32], err};
  assign db_ext  = {3'b000, deadband_q};
  assign in_band = (err_ext >= -db_ext) && (err_ext <= db_ext);

  // next state and first stage word
  always_comb begin
    logic       done;
    logic [31:0] stall_new;
    done        = 1'b0;
    stall_new   = '0;
    mode_d      = mode_q;
    prev_tick_d = prev_tick_q;
    home_el_d   = home_el_q;
    stall_el_d  = stall_el_q;
    pos_d       = pos_q;
    tgt_d       = tgt_q;
    prop1_d     = 1'b0;
    negerr1_d   = -err;
    res1_d                  = '0;
    res1_d.motor_command    = CMD_NONE;

    unique case (in_ch.data.action)
      ACT_INIT: begin
        mode_d      = MODE_IDLE;
        prev_tick_d = '0;
        home_el_d   = '0;
        stall_el_d  = '0;
        pos_d       = sensed;
        tgt_d       = TARGET_NONE;
      end
      ACT_HOME: begin
        mode_d               = MODE_HOMING;
        home_el_d            = '0;
        stall_el_d           = '0;
        res1_d.motor_command = CMD_SET_DUTY;
        res1_d.duty_out      = 16'(HOMING_DUTY);
      end
      ACT_MOVE: begin
        if (mode_q != MODE_HOMING) begin
          tgt_d                   = move_tgt;
          mode_d                  = MODE_MOVING;
          res1_d.command_accepted = 1'b1;
        end
      end
      ACT_DUTY: begin
        if (mode_q != MODE_HOMING && mode_q != MODE_MOVING) begin
          res1_d.motor_command    = CMD_SET_DUTY;
          res1_d.duty_out         = in_ch.data.requested_duty;
          res1_d.command_accepted = 1'b1;
        end
      end
      ACT_TICK: begin
        prev_tick_d = in_ch.data.now_ms;
        // homing: timeout, then stall detection after the minimum run
        if (mode_q == MODE_HOMING) begin
          home_el_d = home_sat;
          if (home_sat >= home_timeout_q) begin
            res1_d.motor_command = CMD_STOP;
            mode_d               = MODE_FAULT;
            done                 = 1'b1;
          end else if (home_sat >= home_min_run_q) begin
            stall_new  = is_still ? stall_sat : '0;
            stall_el_d = stall_new;
            if (stall_new >= stall_stable_q) begin
              res1_d.motor_command = CMD_STOP;
              res1_d.counter_reset = 1'b1;
              pos_d                = '0;
              mode_d               = MODE_HOMED;
              done                 = 1'b1;
            end
          end
        end
        // moving: arrive inside the deadband, else proportional duty
        if (mode_q == MODE_MOVING) begin
          if (in_band) begin
            res1_d.motor_command = CMD_STOP;
            mode_d               = MODE_HOMED;
          end else begin
            res1_d.motor_command = CMD_SET_DUTY;
            prop1_d              = 1'b1;
          end
        end
        if (!done) begin
          pos_d = sensed;
        end
      end
      default: ;
    endcase

    res1_d.controller_state = mode_d;
    res1_d.position_out     = pos_d;
    res1_d.target_out       = tgt_d;
  end

  // controller state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_UNINIT;
      prev_tick_q <= '0;
      home_el_q   <= '0;
      stall_el_q  <= '0;
      pos_q       <= '0;
      tgt_q       <= TARGET_NONE;
    end else if (in_acc) begin
      mode_q      <= mode_d;
      prev_tick_q <= prev_tick_d;
      home_el_q   <= home_el_d;
      stall_el_q  <= stall_el_d;
      pos_q       <= pos_d;
      tgt_q       <= tgt_d;
    end
  end

  // gain product
  assign gain_s  = {1'b0, gain_num_q};
  assign prod2_d = negerr1_q * gain_s;

  // magnitude, clamp flag and reciprocal product
  assign mag3     = prod2_q[49] ? 50'(-prod2_q) : 50'(prod2_q);
  assign recip3_d = PrdW'(mag3[NumW-1:0]) * PrdW'(Recip);

  // final minimum raise and maximum clamp
  assign quot    = recip3_q >> RecipS;
  assign raised  = (quot < PrdW'(MIN_DUTY)) ? PrdW'(MIN_DUTY) : quot;
  assign limited = (raised > PrdW'(MAX_DUTY)) ? PrdW'(MAX_DUTY) : raised;
  assign fin_mag = sat3_q ? PrdW'(MAX_DUTY) : ((quot == '0) ? '0 : limited);
  assign prop_duty = neg3_q ? -16'(fin_mag) : 16'(fin_mag);

  // result word with the proportional duty merged in
  always_comb begin
    out_d = res3_q;
    if (prop3_q) begin
      out_d.duty_out = prop_duty;
    end
  end

  // pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= in_acc;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
      if (rdy_o) begin
        vo_q <= v3_q;
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res1_q    <= res1_d;
      prop1_q   <= prop1_d;
      negerr1_q <= negerr1_d;
    end
    if (v1_q && rdy2) begin
      res2_q  <= res1_q;
      prop2_q <= prop1_q;
      prod2_q <= prod2_d;
    end
    if (v2_q && rdy3) begin
      res3_q   <= res2_q;
      prop3_q  <= prop2_q;
      neg3_q   <= prod2_q[49];
      sat3_q   <= (mag3 >= 50'(ScaleLim));
      recip3_q <= recip3_d;
    end
    if (v3_q && rdy_o) begin
      out_q <= out_d;
    end
  end

  assign out_ch.valid = vo_q;
  assign out_ch.data  = out_q;

endmodule

FILE: dv/actuator_homing_and_position_controller_core_test.sv
`timescale 1ns / 100ps

module actuator_homing_and_position_controller_core_test;
  import ahpc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 10;
  localparam int HOLD_CYCLES    = 40;
  localparam int PHASE_WORDS    = 195;
  localparam int TICK_STEP      = 40;
  localparam int REPORT_CAP     = 60;
  localparam int NUM_PHASES     = 8;

  // action codes the block ignores
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;

  // tracks controller state and holds the results still owed by the block
  class controller_board;
    logic signed [31:0] pos_min;
    logic signed [31:0] pos_max;
    logic [31:0]        home_timeout;
    logic [31:0]        home_min_run;
    logic [14:0]        stall_thr;
    logic [31:0]        stall_stable;
    logic [30:0]        deadband;
    logic [15:0]        gain_num;

    logic [2:0]         mode;
    logic [31:0]        last_tick;
    logic [31:0]        home_elapsed;
    logic [31:0]        stall_elapsed;
    logic signed [31:0] position;
    logic signed [31:0] target;

    out_word_t          motor_results[$];
    int                 errors;
    int                 reported;

    function new();
      pos_min       = RST_POS_MIN;
      pos_max       = RST_POS_MAX;
      home_timeout  = RST_HOME_TIMEOUT;
      home_min_run  = RST_HOME_MIN_RUN;
      stall_thr     = RST_STALL_THR;
      stall_stable  = RST_STALL_STABLE;
      deadband      = RST_MOVE_DEADBAND;
      gain_num      = RST_GAIN_NUM;
      mode          = MODE_UNINIT;
      last_tick     = '0;
      home_elapsed  = '0;
      stall_elapsed = '0;
      position      = '0;
      target        = TARGET_NONE;
      errors        = 0;
      reported      = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
      case (idx)
        REG_POS_MIN:       pos_min = v;
        REG_POS_MAX:       pos_max = v;
        REG_HOME_TIMEOUT:  home_timeout = v;
        REG_HOME_MIN_RUN:  home_min_run = v;
        REG_STALL_THR:     stall_thr = v[14:0];
        REG_STALL_STABLE:  stall_stable = v;
        REG_MOVE_DEADBAND: deadband = v[30:0];
        REG_GAIN_NUM:      gain_num = v[15:0];
        default: ;
      endcase
    endfunction

    function logic signed [31:0] clamp_count(longint v);
      if (v < longint'(pos_min)) return pos_min;
      if (v > longint'(pos_max)) return pos_max;
      return v[31:0];
    endfunction

    function logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    // one controller step: updates state, returns the result word
    function out_word_t step_controller(in_word_t w);
      out_word_t          r;
      logic [31:0]        dt;
      bit                 settled;
      logic signed [31:0] sensed;
      longint             err;
      longint             band;
      longint             drive;
      longint             speed;
      r = '0;
      sensed = clamp_count(longint'(DEF_COUNT_SIGN) * longint'($signed(w.raw_count)));
      case (w.action)
        ACT_INIT: begin
          mode          = MODE_IDLE;
          last_tick     = '0;
          home_elapsed  = '0;
          stall_elapsed = '0;
          position      = sensed;
          target        = TARGET_NONE;
        end
        ACT_HOME: begin
          mode            = MODE_HOMING;
          home_elapsed    = '0;
          stall_elapsed   = '0;
          r.motor_command = CMD_SET_DUTY;
          r.duty_out      = 16'(DEF_HOMING_DUTY);
        end
        ACT_MOVE: begin
          if (mode != MODE_HOMING) begin
            target             = clamp_count(longint'($signed(w.target_position)));
            mode               = MODE_MOVING;
            r.command_accepted = 1'b1;
          end
        end
        ACT_DUTY: begin
          if (mode != MODE_HOMING && mode != MODE_MOVING) begin
            r.motor_command    = CMD_SET_DUTY;
            r.duty_out         = w.requested_duty;
            r.command_accepted = 1'b1;
          end
        end
        ACT_TICK: begin
          // a zero previous stamp means no time has passed
          dt = (last_tick != '0) ? w.now_ms - last_tick : 32'd0;
          last_tick = w.now_ms;
          settled = 1'b0;
          speed = longint'($signed(w.measured_speed));
          // homing: timeout first, then stall detection after the minimum run
          if (mode == MODE_HOMING) begin
            home_elapsed = add_sat(home_elapsed, dt);
            if (home_elapsed >= home_timeout) begin
              r.motor_command = CMD_STOP;
              mode            = MODE_FAULT;
              settled         = 1'b1;
            end else if (home_elapsed >= home_min_run) begin
              if (speed <= longint'(stall_thr) && speed >= -longint'(stall_thr))
                stall_elapsed = add_sat(stall_elapsed, dt);
              else
                stall_elapsed = '0;
              if (stall_elapsed >= stall_stable) begin
                r.motor_command = CMD_STOP;
                r.counter_reset = 1'b1;
                position        = '0;
                mode            = MODE_HOMED;
                settled         = 1'b1;
              end
            end
          end
          // moving: stop inside the deadband, else proportional drive with minimum and maximum magnitude
          if (!settled && mode == MODE_MOVING) begin
            position = sensed;
            err  = longint'(target) - longint'(position);
            band = longint'(deadband);
            if (err >= -band && err <= band) begin
              r.motor_command = CMD_STOP;
              mode            = MODE_HOMED;
              settled         = 1'b1;
            end else begin
              drive = (-err * longint'(gain_num)) / longint'(DEF_GAIN_DENOMINATOR);
              if (drive > 0 && drive < DEF_MIN_DUTY)
                drive = DEF_MIN_DUTY;
              else if (drive < 0 && drive > -DEF_MIN_DUTY)
                drive = -DEF_MIN_DUTY;
              if (drive > DEF_MAX_DUTY)
                drive = DEF_MAX_DUTY;
              else if (drive < -DEF_MAX_DUTY)
                drive = -DEF_MAX_DUTY;
              r.motor_command = CMD_SET_DUTY;
              r.duty_out      = drive[15:0];
            end
          end
          if (!settled) position = sensed;
        end
        default: ;
      endcase
      r.controller_state = mode;
      r.position_out     = position;
      r.target_out       = target;
      return r;
    endfunction

    function void note_word(in_word_t w);
      motor_results.push_back(step_controller(w));
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        if (reported < REPORT_CAP)
          $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
        reported++;
      end
    endfunction

    function void check_word(out_word_t got);
      out_word_t want;
      if (motor_results.size() == 0) begin
        errors++;
        if (reported < REPORT_CAP)
          $display("%0t: result word with none pending: expected none, actual %h",
                   $time, got);
        reported++;
        return;
      end
      want = motor_results.pop_front();
      compare_field("motor_command", want.motor_command, got.motor_command);
      compare_field("duty_out", want.duty_out, got.duty_out);
      compare_field("counter_reset", want.counter_reset, got.counter_reset);
      compare_field("controller_state", want.controller_state, got.controller_state);
      compare_field("position_out", want.position_out, got.position_out);
      compare_field("target_out", want.target_out, got.target_out);
      compare_field("command_accepted", want.command_accepted, got.command_accepted);
    endfunction
  endclass

  bit                    clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  ahpc_in_if  in_ch ();
  ahpc_out_if out_ch ();

  controller_board board = new();

  int          tx_idle_pct  = 0;
  int          rx_stall_pct = 0;
  bit          hold_request = 1'b0;
  int          words_sent   = 0;
  int          quiet_cycles = 0;
  logic [31:0] clock_ms     = '0;
  logic [31:0] reg_shadow [8] = '{RST_POS_MIN, RST_POS_MAX, RST_HOME_TIMEOUT,
                                  RST_HOME_MIN_RUN, 32'(RST_STALL_THR), RST_STALL_STABLE,
                                  32'(RST_MOVE_DEADBAND), 32'(RST_GAIN_NUM)};
  longint      win_lo = 0;
  longint      win_hi = 65535;

  actuator_homing_and_position_controller_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  // clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // words taken and returned at each rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) board.check_word(out_ch.data);
      if (in_ch.valid && in_ch.ready) board.note_word(in_ch.data);
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  always begin
    @(negedge clk_i);
    if (hold_request) begin
      out_ch.ready <= 1'b0;
      repeat (HOLD_CYCLES) @(negedge clk_i);
      hold_request = 1'b0;
    end
    out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
  end

  function automatic logic signed [31:0] to_count(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic in_word_t noise_word();
    in_word_t w;
    w.action          = 3'($urandom_range(7));
    w.now_ms          = $urandom();
    w.measured_speed  = 16'($urandom());
    w.raw_count       = $urandom();
    w.target_position = $urandom();
    w.requested_duty  = 16'($urandom());
    return w;
  endfunction

  // counts mostly near the allowed window, some anywhere
  function automatic logic signed [31:0] pick_count();
    longint span;
    longint v;
    if ($urandom_range(99) < 15) return $urandom();
    span = win_hi - win_lo;
    if (span > longint'(32'hFFFF_FFFF))
      v = win_lo + longint'($urandom());
    else
      v = win_lo + longint'($urandom_range(span[31:0]));
    return to_count(v);
  endfunction

  // speeds mostly inside the stall threshold, some just outside, some anywhere
  function automatic logic signed [15:0] pick_speed();
    int unsigned mag;
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 65) mag = $urandom_range(reg_shadow[REG_STALL_THR][14:0]);
    else if (roll < 75) mag = reg_shadow[REG_STALL_THR][14:0] + 1;
    else return 16'($urandom());
    return ($urandom_range(1) != 0) ? -16'(mag) : 16'(mag);
  endfunction

  // time stamps: mostly forward steps, sometimes zero, jumps or near the wrap
  function automatic void advance_clock();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 2) clock_ms = '0;
    else if (roll < 5) clock_ms = $urandom();
    else if (roll < 7) clock_ms = 32'hFFFF_FFFF - $urandom_range(30);
    else clock_ms = clock_ms + $urandom_range(TICK_STEP, 1);
  endfunction

  function automatic void set_window();
    longint lo;
    longint hi;
    lo = longint'($signed(reg_shadow[REG_POS_MIN]));
    hi = longint'($signed(reg_shadow[REG_POS_MAX]));
    if (lo > hi) begin
      win_lo = hi - 64;
      win_hi = lo + 64;
    end else begin
      win_lo = lo - 64;
      win_hi = hi + 64;
    end
  endfunction

  // present one word and hold it until taken
  task automatic send_word(input in_word_t w);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    words_sent++;
  endtask

  task automatic send_tick(input logic [31:0] now, input logic signed [15:0] speed,
                           input logic signed [31:0] raw);
    in_word_t w;
    w = noise_word();
    w.action         = ACT_TICK;
    w.now_ms         = now;
    w.measured_speed = speed;
    w.raw_count      = raw;
    send_word(w);
  endtask

  // command word with its argument in the field the action uses
  task automatic send_action(input logic [2:0] act, input logic [31:0] arg);
    in_word_t w;
    w = noise_word();
    w.action = act;
    case (act)
      ACT_INIT: w.raw_count = arg;
      ACT_MOVE: w.target_position = arg;
      ACT_DUTY: w.requested_duty = arg[15:0];
      default: ;
    endcase
    send_word(w);
  endtask

  task automatic program_regs(input logic [31:0] vals [8]);
    for (int i = 0; i < 8; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= i[CFG_IDX_W-1:0];
      cfg_data <= vals[i];
      @(negedge clk_i);
      board.write_reg(i[CFG_IDX_W-1:0], vals[i]);
      reg_shadow[i] = vals[i];
    end
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (board.motor_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // random traffic: homing runs, moves that converge, commands and noise
  task automatic run_phase(input int budget);
    int     stop_at;
    int     pick;
    int     n;
    longint tgt;
    longint pos;
    longint band;
    stop_at = words_sent + budget;
    while (words_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        send_action(ACT_HOME, $urandom());
        n = $urandom_range(25, 3);
        repeat (n) begin
          advance_clock();
          send_tick(clock_ms, pick_speed(), pick_count());
        end
      end else if (pick < 60) begin
        tgt = longint'(pick_count());
        send_action(ACT_MOVE, to_count(tgt));
        pos  = longint'(pick_count());
        band = longint'(reg_shadow[REG_MOVE_DEADBAND][30:0]);
        if (band > 1000) band = 1000;
        n = $urandom_range(12, 2);
        for (int i = 0; i < n; i++) begin
          if (i == n - 1)
            pos = tgt + longint'($urandom_range(2 * band)) - band;
          else
            pos = pos + (tgt - pos) / longint'($urandom_range(4, 2))
                  + longint'($urandom_range(6)) - 3;
          advance_clock();
          send_tick(clock_ms, 16'($urandom()), to_count(pos));
        end
      end else if (pick < 70) begin
        send_action(ACT_DUTY, $urandom());
      end else if (pick < 80) begin
        send_action(ACT_INIT, pick_count());
      end else begin
        send_word(noise_word());
      end
    end
  endtask

  initial begin
    logic [31:0] vals [8];
    rst_ni       = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = '0;
    cfg_data     = '0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // before init the position follows the raw count; first tick counts no time
    send_tick(32'd0, 16'sd0, 32'sd5);
    send_action(ACT_SPARE_HI, 32'hFFFF_FFFF);
    send_action(ACT_DUTY, 32'h0000_8000);
    send_action(ACT_INIT, 32'd70000);
    send_action(ACT_INIT, -32'sd5);
    send_action(ACT_DUTY, 32'h0000_7FFF);
    // proportional drive at full scale, at minimum magnitude, then arrival
    send_action(ACT_MOVE, 32'd1000);
    send_tick(32'd100, 16'sd0, 32'sd0);
    send_tick(32'd110, 16'sd0, 32'sd990);
    send_tick(32'd120, 16'sd0, 32'sd998);
    send_action(ACT_MOVE, 32'h8000_0000);
    send_tick(32'd130, 16'sd0, 32'sh7FFF_FFFF);
    send_action(ACT_DUTY, 32'd1234);
    // homing refuses commands, the stall window breaks once, then completes
    send_action(ACT_HOME, '0);
    send_action(ACT_MOVE, 32'd10);
    send_action(ACT_DUTY, 32'hFFFF_FFFF);
    send_tick(32'd200, 16'sh7FFF, 32'sd5);
    send_tick(32'd400, 16'sd10, 32'sd5);
    send_tick(32'd500, -16'sd10, 32'sd5);
    send_tick(32'd550, 16'sd11, 32'sd5);
    send_tick(32'd700, 16'sd10, 32'sd5);
    send_tick(32'd760, -16'sd1, 32'sd5);
    // homing timeout, then a tick across the time wrap
    send_action(ACT_HOME, '0);
    send_tick(32'hFFFF_FFF0, 16'sd0, 32'sd5);
    send_action(ACT_HOME, '0);
    send_tick(32'h0000_0020, 16'sd0, 32'sd5);

    for (int p = 0; p < NUM_PHASES; p++) begin
      in_ch.valid <= 1'b0;
      wait_drained();
      case (p)
        0: vals = '{-32'sd1000, 32'sd1000, 32'd400, 32'd20, 32'd10, 32'd30, 32'd5, 32'd16};
        // widest limits, all-ones writes; deadband write keeps only zeros
        1: vals = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF,
                    32'd0, 32'h8000_0000, 32'hFFFF_FFFF};
        2: vals = '{32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'h0000_8000, 32'hFFFF_FFFF,
                    32'h7FFF_FFFF, 32'd0};
        // limits swapped
        3: vals = '{32'sd500, -32'sd500, 32'd300, 32'd10, 32'd100, 32'd40, 32'd20, 32'd3};
        default: begin
          vals = '{-$urandom_range(100000), $urandom_range(100000), $urandom_range(2000, 100),
                   $urandom_range(100), $urandom_range(200), $urandom_range(100),
                   $urandom_range(50), $urandom_range(200, 1)};
          if (p == 5) vals[REG_HOME_TIMEOUT] = 32'hFFFF_FFFF;
        end
      endcase
      program_regs(vals);
      set_window();
      tx_idle_pct  = (p % 4 == 1) ? 59 : (p % 4 == 3) ? 25 : 0;
      rx_stall_pct = (p % 4 == 2) ? 59 : (p % 4 == 3) ? 25 : 0;
      hold_request = (p == 0);
      run_phase(PHASE_WORDS);
    end

    in_ch.valid <= 1'b0;
    wait_drained();
    if (board.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
